[design/lpm_pkg.sv]
// Shared types and constants for the IPv4 longest-prefix-match table.
// No dependencies; compile first.
`default_nettype none

package lpm_pkg;

    localparam int ADDR_BITS = 32;
    localparam int LEN_BITS  = 6;
    localparam int RID_BITS  = 16;

    localparam logic [LEN_BITS-1:0] PREFIX_MAX = 6'd32;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic                  opcode;
        logic [ADDR_BITS-1:0]  address;
        logic [LEN_BITS-1:0]   prefix_len;
        logic [RID_BITS-1:0]   route_id;
    } t_req;

    typedef struct packed {
        logic                  hit;
        logic [RID_BITS-1:0]   found_id;
        logic [LEN_BITS-1:0]   matched_len;
        logic                  status;
    } t_rsp;

    // Leading-ones mask for a prefix length of 0..32.
    function automatic logic [ADDR_BITS-1:0] f_prefix_mask(logic [LEN_BITS-1:0] len);
        logic [ADDR_BITS-1:0] mask;
        if (len == '0) begin
            mask = '0;
        end else begin
            mask = {ADDR_BITS{1'b1}} << (PREFIX_MAX - len);
        end
        return mask;
    endfunction

endpackage

`default_nettype wire

[design/lpm_req_if.sv]
// Request channel: valid/ready handshake carrying one insert or lookup word.
// Depends on lpm_pkg.
`default_nettype none

interface lpm_req_if import lpm_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/lpm_rsp_if.sv]
// Response channel: valid/ready handshake carrying one result word.
// Depends on lpm_pkg.
`default_nettype none

interface lpm_rsp_if import lpm_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/ipv4_longest_prefix_match_top.sv]
// IPv4 longest-prefix-match routing table with a one-entry-per-cycle scan.
// Depends on lpm_pkg, lpm_req_if and lpm_rsp_if.
//
// Usage:
//   i_req carries one word per item: opcode 0 inserts address/prefix_len/route_id,
//   opcode 1 looks up address. o_rsp returns exactly one result word per item.
//   Routes live in a TABLE_DEPTH-entry memory, filled in order; entries below
//   the fill count are valid. Each item scans the filled entries through the
//   single read port, one entry per cycle, with one shared compare unit.
//   Latency from accept to o_rsp.valid grows with the fill count, as the scan
//   visits each filled entry through the registered memory read; the next item
//   is taken in the cycle after the result is loaded, so items do not overlap.
//   i_req.ready is high only while the sequencer is idle.
//   A stalled receiver holds the result in the output register; the sequencer
//   waits with its finished result until that register frees up.
//   Reset (synchronous, active low) empties the table at once by clearing the
//   fill count; no clearing pass runs.
`default_nettype none

module ipv4_longest_prefix_match_top import lpm_pkg::*; #(
    parameter int TABLE_DEPTH = 32,
    parameter int ID_BITS     = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lpm_req_if.sink    i_req,
    lpm_rsp_if.source  o_rsp
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = (ID_BITS < RID_BITS) ? ID_BITS : RID_BITS;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    typedef struct packed {
        logic [ADDR_BITS-1:0] prefix;
        logic [LEN_BITS-1:0]  length;
        logic [SW-1:0]        id;
    } t_entry;

    // route memory
    t_entry r_mem [0:TABLE_DEPTH-1];
    t_entry r_rd_data;

    // control
    logic [1:0]    r_state;
    logic [CW-1:0] r_fill;
    logic [CW-1:0] r_idx;
    logic          r_pend;
    logic [AW-1:0] r_pend_idx;
    logic          r_out_vld;

    // item being worked on
    logic                  r_op;
    logic [ADDR_BITS-1:0]  r_addr;
    logic [LEN_BITS-1:0]   r_len;
    logic [SW-1:0]         r_rid;
    logic                  r_hit;
    logic [LEN_BITS-1:0]   r_best_len;
    logic [SW-1:0]         r_best_id;
    logic [AW-1:0]         r_dup_idx;
    t_rsp                  r_rsp;

    logic                  w_accept;
    logic                  w_issue;
    logic                  w_out_free;
    logic                  w_finish;
    logic                  w_full;
    logic                  w_match;
    logic [LEN_BITS-1:0]   w_len_sat;
    logic                  w_wr_en;
    logic [AW-1:0]         w_wr_addr;
    t_entry                w_wr_data;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_issue     = (r_idx < r_fill);
    assign w_out_free  = !r_out_vld || o_rsp.ready;
    assign w_finish    = (r_state == S_DONE) && w_out_free;
    assign w_full      = (r_fill >= DEPTH_C);
    assign w_len_sat   = (i_req.data.prefix_len > PREFIX_MAX) ? PREFIX_MAX
                                                              : i_req.data.prefix_len;

    // shared compare unit: lookup tests the address under the entry's mask,
    // insert tests for the same prefix and length
    always_comb begin
        if (r_op == OP_LOOKUP) begin
            w_match = ((r_addr & f_prefix_mask(r_rd_data.length)) == r_rd_data.prefix);
        end else begin
            w_match = (r_rd_data.length == r_len) && (r_rd_data.prefix == r_addr);
        end
    end

    always_comb begin
        w_wr_en   = w_finish && (r_op == OP_INSERT) && (r_hit || !w_full);
        w_wr_addr = r_hit ? r_dup_idx : r_fill[AW-1:0];
        w_wr_data = '{prefix: r_addr, length: r_len, id: r_rid};
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_idx[AW-1:0]];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_idx     <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_finish) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.valid && o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_idx   <= '0;
                        r_pend  <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_issue) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    r_pend <= w_issue;
                    if (!w_issue && !r_pend) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                        if (r_op == OP_INSERT && !r_hit && !w_full) begin
                            r_fill <= r_fill + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_pend_idx <= r_idx[AW-1:0];
        if (w_accept) begin
            r_op       <= i_req.data.opcode;
            r_len      <= w_len_sat;
            r_rid      <= i_req.data.route_id[SW-1:0];
            r_hit      <= 1'b0;
            r_best_len <= '0;
            r_best_id  <= '0;
            if (i_req.data.opcode == OP_INSERT) begin
                r_addr <= i_req.data.address & f_prefix_mask(w_len_sat);
            end else begin
                r_addr <= i_req.data.address;
            end
        end else if (r_state == S_SCAN && r_pend && w_match) begin
            if (r_op == OP_LOOKUP) begin
                // keep the earliest entry among equal lengths
                if (!r_hit || r_rd_data.length > r_best_len) begin
                    r_hit      <= 1'b1;
                    r_best_len <= r_rd_data.length;
                    r_best_id  <= r_rd_data.id;
                end
            end else if (!r_hit) begin
                r_hit     <= 1'b1;
                r_dup_idx <= r_pend_idx;
            end
        end
        if (w_finish) begin
            if (r_op == OP_LOOKUP) begin
                r_rsp.hit         <= r_hit;
                r_rsp.found_id    <= RID_BITS'(r_best_id);
                r_rsp.matched_len <= r_best_len;
                r_rsp.status      <= STATUS_OK;
            end else begin
                r_rsp.hit         <= 1'b0;
                r_rsp.found_id    <= '0;
                r_rsp.matched_len <= '0;
                r_rsp.status      <= (!r_hit && w_full) ? STATUS_FULL : STATUS_OK;
            end
        end
    end

    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_rsp;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= DEPTH_C)
        else $error("fill count exceeds table depth");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_fill)
        else $error("scan index ran past fill count");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_fill != $past(r_fill)) |->
            ($past(r_state) == S_DONE && r_fill == $past(r_fill) + 1'b1))
        else $error("fill count moved outside insert completion");

    a_rsp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_out_vld)) |-> ($past(r_state) == S_DONE))
        else $error("result raised without a finished item");

    a_write_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (r_state == S_DONE && !r_pend))
        else $error("table written during scan");

endmodule

`default_nettype wire
